// File: rtl/bvs_pkg.sv
// Shared constants, codes and types of the bucketed value set store.
package bvs_pkg;

  localparam int NUM_BINS      = 1024;
  localparam int SLOTS_PER_BIN = 8;

  localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SLOT_W    = (SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1;
  localparam int CNT_W     = $clog2(SLOTS_PER_BIN + 1);
  localparam int DAT_AW    = BIN_W + SLOT_W;
  localparam int DAT_DEPTH = 2 ** DAT_AW;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 10;
  localparam int IDX_EXT_W = (IDX_W > BIN_W) ? IDX_W : BIN_W;
  localparam int BINS_W    = 11;
  localparam int HALF_W    = 64;
  localparam int VAL_W     = 2 * HALF_W;
  localparam int STAT_W    = 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_BINS_IN_USE = '0;
  localparam logic [BINS_W-1:0]    BINS_RESET      = BINS_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [BINS_W-1:0] bins_in_use;
  } cfg_t;

endpackage

// File: rtl/bvs_if.sv
// Request and response channel interfaces.
interface bvs_req_if import bvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  bin_sel;
  logic [HALF_W-1:0] value_high;
  logic [HALF_W-1:0] value_low;

  modport source (output valid, output op, output bin_sel, output value_high,
                  output value_low, input ready);
  modport sink   (input valid, input op, input bin_sel, input value_high,
                  input value_low, output ready);
endinterface

interface bvs_rsp_if import bvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;

  modport source (output valid, output status, output found, input ready);
  modport sink   (input valid, input status, input found, output ready);
endinterface

// File: rtl/bvs_ram.sv
// Generic simple dual-port RAM with registered read.
module bvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bvs_cfg.sv
// APB configuration register block.
module bvs_cfg import bvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [BINS_W-1:0]    bins_q, bins_d;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    bins_d = bins_q;
    if (psel && penable && pwrite && (reg_idx == REG_BINS_IN_USE)) begin
      bins_d = pwdata[BINS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_RESET;
    end else begin
      bins_q <= bins_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_BINS_IN_USE) begin
      prdata = PDATA_W'(bins_q);
    end
  end

  assign cfg_o.bins_in_use = bins_q;

endmodule

// File: rtl/bvs_engine.sv
// Per-item sequencer: fill-count RAM, slot RAM, bin scan and result register.
module bvs_engine import bvs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  bvs_req_if.sink   req_i,
  bvs_rsp_if.source rsp_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDCNT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;

  localparam logic [BIN_W-1:0] BIN_LAST  = BIN_W'(NUM_BINS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(SLOTS_PER_BIN);

  logic [2:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [BIN_W-1:0]  clr_q, clr_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic              out_found_q, out_found_d;

  // count RAM: slots filled per bin (bins fill as a prefix, zero never stored)
  logic              cnt_we, cnt_re;
  logic [BIN_W-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  // slot RAM: values, addressed {bin, slot}
  logic              dat_we, dat_re;
  logic [DAT_AW-1:0] dat_waddr, dat_raddr;
  logic [VAL_W-1:0]  dat_rdata;

  logic                 in_fire;
  logic                 in_range;
  logic [IDX_EXT_W-1:0] in_bin_ext;
  logic [BIN_W-1:0]     in_bin;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign in_bin_ext  = IDX_EXT_W'(req_i.bin_sel);
  assign in_bin      = in_bin_ext[BIN_W-1:0];
  assign in_range    = (BINS_W'(req_i.bin_sel) < cfg_i.bins_in_use) &&
                       (32'(req_i.bin_sel) < 32'(NUM_BINS));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    bin_d        = bin_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;

    cnt_we    = 1'b0;
    cnt_waddr = bin_q;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = in_bin;
    dat_we    = 1'b0;
    dat_waddr = {bin_q, SLOT_W'(cnt_rdata)};
    dat_re    = 1'b0;
    dat_raddr = {bin_q, slot_q};

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + BIN_W'(1);
        if (clr_q == BIN_LAST) begin
          clr_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_FIN;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_d         = req_i.op;
          bin_d        = in_bin;
          val_d        = {req_i.value_high, req_i.value_low};
          slot_d       = '0;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          if (req_i.op == OP_CLEAR) begin
            state_d = S_CLR;
          end else if (req_i.op == OP_APPEND || req_i.op == OP_QUERY) begin
            if (!in_range) begin
              res_status_d = ST_RANGE;
              state_d      = S_FIN;
            end else begin
              cnt_re  = 1'b1;
              state_d = S_RDCNT;
            end
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_RDCNT: begin
        cnt_d   = cnt_rdata;
        state_d = S_FIN;
        if (op_q == OP_APPEND) begin
          if (val_q != '0) begin
            if (cnt_rdata == CNT_FULL) begin
              res_status_d = ST_FULL;
            end else begin
              dat_we    = 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata + CNT_W'(1);
            end
          end
        end else begin
          if (val_q == '0) begin
            // zero matches any empty slot
            res_found_d = (cnt_rdata != CNT_FULL);
          end else if (cnt_rdata != '0) begin
            dat_re    = 1'b1;
            dat_raddr = {bin_q, SLOT_W'(0)};
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (dat_rdata == val_q) begin
          res_found_d = 1'b1;
          state_d     = S_FIN;
        end else if ((CNT_W'(slot_q) + CNT_W'(1)) == cnt_q) begin
          state_d = S_FIN;
        end else begin
          slot_d    = slot_q + SLOT_W'(1);
          dat_re    = 1'b1;
          dat_raddr = {bin_q, slot_q + SLOT_W'(1)};
        end
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    bin_q        <= bin_d;
    val_q        <= val_d;
    cnt_q        <= cnt_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
  end

  bvs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  bvs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DAT_DEPTH)
  ) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (val_q),
    .re_i    (dat_re),
    .raddr_i (dat_raddr),
    .rdata_o (dat_rdata)
  );

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.found  = out_found_q;

`ifndef SYNTHESIS
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dat_we |-> (state_q == S_RDCNT) && (cnt_rdata < CNT_FULL))
    else $error("slot write into a full bin");

  a_scan_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(slot_q) < cnt_q))
    else $error("scan beyond filled slots");

  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_i.op == OP_CLEAR)) |=> (state_q == S_CLR) && (clr_q == '0))
    else $error("clear item did not start sweep");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (cnt_wdata <= CNT_FULL))
    else $error("fill count overflow");
`endif

endmodule

// File: rtl/bucketed_value_set_store_core.sv
// Top level of the bucketed value set store.
//
//  channel   dir   handshake        payload
//  in_i      in    valid/ready      op, bin_sel, value_high, value_low
//  out_o     out   valid/ready      status, found
//  apb       in    psel/penable     paddr, pwdata -> prdata (pready tied high)
//
// One item at a time. Append: the item passes S_RDCNT and S_FIN to the result
// register; out-of-range and unused op go straight to S_FIN. Query: as append, with
// one S_SCAN step per filled slot scanned (up to SLOTS_PER_BIN), paced by the single
// read port of the slot RAM. Clear: one fill-count RAM entry zeroed per cycle.
// After reset a sweep zeroes the fill counts; no item is taken then.
// A result waiting in the output register stalls only the next item's finish.
module bucketed_value_set_store_core import bvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  bvs_req_if.sink            in_i,
  bvs_rsp_if.source          out_o
);

  cfg_t cfg;

  bvs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bvs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (in_i),
    .rsp_o  (out_o)
  );

endmodule

// File: tb/bvs_result_checker.sv
// Checker for the bucketed value set store: mirrors the bins and compares every result.
module bvs_result_checker import bvs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  bvs_req_if                 req,
  bvs_rsp_if                 rsp,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    status_e status;
    logic    found;
  } bvs_result_t;

  logic [VAL_W-1:0]  slot_mem [NUM_BINS*SLOTS_PER_BIN];
  logic [BINS_W-1:0] bins_cfg;
  bvs_result_t       result_q [$];
  int                fails;
  int                checked;

  task automatic empty_all_bins();
    for (int i = 0; i < NUM_BINS*SLOTS_PER_BIN; i++) slot_mem[i] = '0;
  endtask

  // Applies one item to the mirrored bins and returns the result it should give.
  task automatic apply_store_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val, output bvs_result_t res);
    int base;
    bit placed;
    res.status = ST_OK;
    res.found  = 1'b0;
    base       = int'(idx) * SLOTS_PER_BIN;
    placed     = 1'b0;
    if (op == OP_CLEAR) begin
      empty_all_bins();
    end else if (op == OP_APPEND || op == OP_QUERY) begin
      if (!({1'b0, idx} < bins_cfg && int'(idx) < NUM_BINS)) begin
        res.status = ST_RANGE;
      end else if (op == OP_APPEND) begin
        // zero value is a no-op, even on a full bin
        if (val != '0) begin
          for (int s = 0; s < SLOTS_PER_BIN; s++) begin
            if (!placed && slot_mem[base+s] == '0) begin
              slot_mem[base+s] = val;
              placed = 1'b1;
            end
          end
          if (!placed) res.status = ST_FULL;
        end
      end else begin
        // a zero query matches any empty slot
        for (int s = 0; s < SLOTS_PER_BIN; s++) begin
          if (slot_mem[base+s] == val) res.found = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bvs_result_t want;
    bvs_result_t next_res;
    if (!rst_ni) begin
      empty_all_bins();
      bins_cfg = BINS_RESET;
      result_q.delete();
      fails    = 0;
      checked  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: result with no item pending: status %0d found %0b",
                   $time, rsp.status, rsp.found);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (rsp.status !== want.status) begin
            fails++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp.status);
          end
          if (rsp.found !== want.found) begin
            fails++;
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, rsp.found);
          end
        end
      end
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_BINS_IN_USE) begin
        if (pwrite) begin
          bins_cfg = pwdata[BINS_W-1:0];
        end else if (prdata !== PDATA_W'(bins_cfg)) begin
          fails++;
          $display("%0t: bins_in_use readback mismatch: expected %0d, actual %0d",
                   $time, bins_cfg, prdata);
        end
      end
      if (req.valid && req.ready) begin
        apply_store_op(req.op, req.bin_sel, {req.value_high, req.value_low}, next_res);
        result_q.push_back(next_res);
      end
    end
    fail_count_o <= fails;
    pending_o    <= result_q.size();
    checked_o    <= checked;
  end

endmodule

// File: tb/tb_bucketed_value_set_store_core.sv
// Testbench top for the bucketed value set store: stimulus, idling, config writes and verdict.
module tb_bucketed_value_set_store_core;
  import bvs_pkg::*;

  localparam longint                TIMEOUT   = 64'd12 * 64'd800_000;
  localparam logic [OP_W-1:0]       OP_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0]    BINS_ADDR = {REG_BINS_IN_USE, 2'b00};
  localparam int                    PHASES    = 6;
  localparam int                    PHASE_LEN = 242;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bvs_req_if req_ch ();
  bvs_rsp_if rsp_ch ();

  int                fail_count;
  int                pending;
  int                checked;
  int                src_idle_pct = 0;
  int                rcv_idle_pct = 0;
  int                items_sent   = 0;
  int                settings_used = 0;
  logic [BINS_W-1:0] bins_now;
  logic [VAL_W-1:0]  value_pool [$];

  bucketed_value_set_store_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (req_ch),
    .out_o   (rsp_ch)
  );

  bvs_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT);
    $display("tb_bucketed_value_set_store_core: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.bin_sel    <= idx;
    req_ch.value_high <= val[VAL_W-1:HALF_W];
    req_ch.value_low  <= val[HALF_W-1:0];
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
    if (op == OP_APPEND && val != '0) begin
      value_pool.push_back(val);
      if (value_pool.size() > 48) void'(value_pool.pop_front());
    end
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every item has produced its result.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= BINS_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_bins(input logic [BINS_W-1:0] nb);
    drain_results();
    apb_access(1'b1, PDATA_W'(nb));
    apb_access(1'b0, '0);
    bins_now = nb;
    settings_used++;
  endtask

  task automatic random_item(input int hot_base);
    int                r;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic [HALF_W-1:0] rh;
    logic [HALF_W-1:0] rl;
    r = $urandom_range(999);
    if (r < 15)       op = OP_CLEAR;
    else if (r < 25)  op = OP_UNUSED;
    else if (r < 480) op = OP_APPEND;
    else              op = OP_QUERY;
    // mostly a few hot bins so they fill up; some anywhere, some at the range edge
    r = $urandom_range(99);
    if (r < 80)      idx = IDX_W'(hot_base + $urandom_range(3));
    else if (r < 90) idx = IDX_W'($urandom);
    else             idx = IDX_W'(int'(bins_now) - int'($urandom_range(1)));
    rh = {$urandom, $urandom};
    rl = {$urandom, $urandom};
    r  = $urandom_range(99);
    if (op == OP_QUERY && value_pool.size() > 0 && r < 50)
      val = value_pool[$urandom_range(value_pool.size() - 1)];
    else if (r < 58) val = '0;
    else if (r < 66) val = {{HALF_W{1'b0}}, rl};
    else if (r < 74) val = {rh, {HALF_W{1'b0}}};
    else             val = {rh, rl};
    send_item(op, idx, val);
  endtask

  initial begin : stimulus
    logic [VAL_W-1:0]  tag;
    logic [BINS_W-1:0] nb;
    int                eff;
    int                hot_base;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_APPEND;
    req_ch.bin_sel    <= '0;
    req_ch.value_high <= '0;
    req_ch.value_low  <= '0;
    bins_now          = BINS_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero value, full bin, unused op, clear
    set_bins(11'd1024);
    tag = {64'h0000_0000_0000_0003, 64'hC3C3_0F0F_55AA_1234};
    send_item(OP_APPEND, 10'd1023, '1);
    send_item(OP_QUERY,  10'd1023, '1);
    send_item(OP_QUERY,  10'd1023, 128'd1);
    send_item(OP_APPEND, 10'd0, '0);
    send_item(OP_QUERY,  10'd0, '0);
    for (int k = 1; k <= SLOTS_PER_BIN; k++)
      send_item(OP_APPEND, 10'd5, {64'(k), 64'hC3C3_0F0F_55AA_1234});
    send_item(OP_APPEND, 10'd5, {64'hFFFF_0000_FFFF_0000, 64'h0});
    send_item(OP_APPEND, 10'd5, '0);
    send_item(OP_QUERY,  10'd5, '0);
    send_item(OP_QUERY,  10'd5, tag);
    send_item(OP_UNUSED, 10'd5, tag);
    send_item(OP_CLEAR,  10'h3FF, '1);
    send_item(OP_QUERY,  10'd5, tag);
    send_item(OP_QUERY,  10'd5, '0);
    // no bin addressable at all
    set_bins(11'd0);
    send_item(OP_APPEND, 10'd0, tag);
    send_item(OP_QUERY,  10'd0, '0);
    set_bins(11'd1);
    send_item(OP_APPEND, 10'd0, tag);
    send_item(OP_APPEND, 10'd1, tag);
    send_item(OP_QUERY,  10'd1023, tag);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       nb = 11'd1024;
        1:       nb = 11'd8;
        2:       nb = 11'd1;
        3:       nb = 11'd2047;
        4:       nb = 11'd200;
        default: nb = 11'd64;
      endcase
      set_bins(nb);
      if (p < 2) begin
        src_idle_pct = 10;
        rcv_idle_pct = 67;
      end else if (p < 4) begin
        src_idle_pct = 67;
        rcv_idle_pct = 10;
      end else begin
        src_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      eff      = (int'(nb) > NUM_BINS) ? NUM_BINS : ((nb == 0) ? 1 : int'(nb));
      hot_base = $urandom_range((eff > 4) ? eff - 4 : 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        // let the pipeline run dry once mid-phase
        if (i == PHASE_LEN / 2) drain_results();
        random_item(hot_base);
      end
    end

    drain_results();
    repeat (NUM_BINS + 64) @(posedge clk_i);
    $display("Run covered %0d items over %0d bins_in_use settings, %0d results checked.",
             items_sent, settings_used, checked);
    $display("Mix: appends into filling bins, hits and misses, zero values, clears, range edges.");
    if (fail_count == 0 && pending == 0)
      $display("tb_bucketed_value_set_store_core: PASS");
    else
      $display("tb_bucketed_value_set_store_core: FAIL");
    $finish;
  end

endmodule
